>>> sv/pocsag_text_transmission_encoder_top_assert.svh
// Assertion macros for the POCSAG text transmission encoder.
`ifndef POCSAG_TEXT_TRANSMISSION_ENCODER_TOP_ASSERT_SVH
`define POCSAG_TEXT_TRANSMISSION_ENCODER_TOP_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define PTTE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define PTTE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle.
`define PTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ptte_pkg.sv
// Shared constants for the POCSAG text transmission encoder.
`default_nettype none

package ptte_pkg;

	localparam int DATA_BITS     = 21;
	localparam int REM_BITS      = 10;
	localparam int CODE_BITS     = 32;
	localparam int BITS_PER_WORD = 20;
	localparam int BITS_PER_CHAR = 7;

	localparam logic [REM_BITS:0]    BCH_GEN          = 11'b11101101001;
	localparam logic [CODE_BITS-1:0] SYNC_WORD        = 32'h7CD215D8;
	localparam logic [CODE_BITS-1:0] IDLE_WORD        = 32'h7A89C197;
	localparam logic [CODE_BITS-1:0] PREAMBLE_PATTERN = 32'hAAAAAAAA;
	localparam logic [DATA_BITS-1:0] MESSAGE_FLAG     = 21'h100000;
	localparam logic [3:0]           BATCH_LAST       = 4'd15;
	localparam logic                 MODE_HEADER      = 1'b0;
	localparam logic                 MODE_CHAR        = 1'b1;

endpackage

`default_nettype wire

>>> sv/ptte_bch.sv
// Bit-serial BCH(31,21) encoder with even parity, one data bit per cycle.
`default_nettype none

module ptte_bch
	import ptte_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DATA_BITS-1:0] data,
	output logic                      busy,
	output logic [CODE_BITS-1:0]      code_word
);

	localparam int CNT_W = $clog2(DATA_BITS + 1);

	logic [DATA_BITS-1:0] data_q;
	logic [DATA_BITS-1:0] shift_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 fb;

	assign fb = shift_q[DATA_BITS-1] ^ rem_q[REM_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q  <= '0;
			shift_q <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (start) begin
			data_q  <= data;
			shift_q <= data;
			rem_q   <= '0;
			cnt_q   <= CNT_W'(DATA_BITS);
			busy_q  <= 1'b1;
		end else if (busy_q) begin
			rem_q   <= {rem_q[REM_BITS-2:0], 1'b0} ^ (fb ? BCH_GEN[REM_BITS-1:0] : '0);
			shift_q <= {shift_q[DATA_BITS-2:0], 1'b0};
			cnt_q   <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign code_word = {data_q, rem_q, ^{data_q, rem_q}};

endmodule

`default_nettype wire

>>> sv/pocsag_text_transmission_encoder_top.sv
// Top level of the POCSAG text transmission encoder: sequencer and output register.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    mode, pager_address, character, end_of_message
// out      out  out_valid / out_ready  code_word, final_word
// cfg      in   cfg_valid / cfg_ready  cfg_data (function code)
//
// One item at a time; in_ready is high only while the sequencer is idle.
// A character that completes no word returns to idle, or moves to the end-of-message state with end of message.
// A character that completes a word waits for the BCH unit, plus a SYNC word at the end of a batch.
// A header sends PREAMBLE_WORDS preamble words, a SYNC, 2 * pager_address[2:0] idle words and the address word.
// Closing words go out one per cycle; a flush codeword waits for the BCH unit; out_ready low holds it.
// Reset clears all state; function code resets to alphanumeric.
`default_nettype none
`include "pocsag_text_transmission_encoder_top_assert.svh"

module pocsag_text_transmission_encoder_top
	import ptte_pkg::*;
#(
	parameter int PREAMBLE_WORDS = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire logic [20:0]           pager_address,
	input  wire logic [6:0]            character,
	input  wire logic                  end_of_message,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [CODE_BITS-1:0]       code_word,
	output logic                       final_word,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_data
);

	localparam int PRE_W = $clog2(PREAMBLE_WORDS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_HSYNC,
		S_PAD,
		S_CW,
		S_BSYNC,
		S_EOM,
		S_CLOSE
	} state_t;

	typedef enum logic [1:0] {
		CW_ADDR,
		CW_MSG,
		CW_FLUSH
	} kind_t;

	state_t                     state_q;
	state_t                     after_word;
	kind_t                      kind_q;
	logic [1:0]                 fc_q;
	logic [BITS_PER_WORD-1:0]   acc_q;
	logic [4:0]                 held_q;
	logic [3:0]                 batch_q;
	logic                       in_msg_q;
	logic                       eom_q;
	logic [2:0]                 frame_q;
	logic [3:0]                 pad_q;
	logic [PRE_W-1:0]           pre_q;
	logic                       out_valid_q;
	logic [CODE_BITS-1:0]       code_word_q;
	logic                       final_word_q;

	logic                       accept;
	logic                       can_emit;
	logic                       emit;
	logic [CODE_BITS-1:0]       emit_word;
	logic                       emit_final;
	logic [BITS_PER_CHAR-1:0]   rev;
	logic [26:0]                joined;
	logic [4:0]                 sum;
	logic                       full;
	logic [2:0]                 ex;
	logic [BITS_PER_WORD-1:0]   word_msg;
	logic [5:0]                 rest_mask;
	logic [BITS_PER_WORD-1:0]   rest_acc;
	logic [BITS_PER_WORD-1:0]   flush_word;
	logic                       bch_start;
	logic [DATA_BITS-1:0]       bch_data;
	logic                       bch_busy;
	logic [CODE_BITS-1:0]       bch_word;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign can_emit  = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < BITS_PER_CHAR; i++) begin
			rev[BITS_PER_CHAR-1-i] = character[i];
		end
	end

	assign joined     = {acc_q, rev};
	assign sum        = held_q + 5'd7;
	assign full       = (sum >= 5'd20);
	assign ex         = 3'(sum - 5'd20);
	assign word_msg   = 20'(joined >> ex);
	assign rest_mask  = ~(6'h3F << ex);
	assign rest_acc   = {14'd0, joined[5:0] & rest_mask};
	assign flush_word = acc_q << (5'd20 - held_q);
	assign after_word = (kind_q == CW_FLUSH) ? S_CLOSE : (eom_q ? S_EOM : S_IDLE);

	always_comb begin
		bch_start = 1'b0;
		bch_data  = MESSAGE_FLAG | {1'b0, word_msg};
		case (state_q)
			S_IDLE: begin
				if (accept && mode == MODE_HEADER) begin
					bch_start = 1'b1;
					bch_data  = {1'b0, pager_address[20:3], fc_q};
				end else if (accept && in_msg_q && full) begin
					bch_start = 1'b1;
				end
			end
			S_EOM: begin
				bch_start = (held_q != 5'd0);
				bch_data  = MESSAGE_FLAG | {1'b0, flush_word};
			end
			default: begin
				bch_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		emit_word  = IDLE_WORD;
		emit_final = 1'b0;
		case (state_q)
			S_PRE: begin
				emit      = can_emit;
				emit_word = PREAMBLE_PATTERN;
			end
			S_HSYNC, S_BSYNC: begin
				emit      = can_emit;
				emit_word = SYNC_WORD;
			end
			S_PAD: begin
				emit = can_emit;
			end
			S_CW: begin
				emit      = can_emit && !bch_busy;
				emit_word = bch_word;
			end
			S_CLOSE: begin
				emit       = can_emit;
				emit_final = (batch_q == BATCH_LAST);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	ptte_bch u_bch (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (bch_start),
		.data      (bch_data),
		.busy      (bch_busy),
		.code_word (bch_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= CW_ADDR;
			fc_q         <= 2'd3;
			acc_q        <= '0;
			held_q       <= '0;
			batch_q      <= '0;
			in_msg_q     <= 1'b0;
			eom_q        <= 1'b0;
			frame_q      <= '0;
			pad_q        <= '0;
			pre_q        <= '0;
			out_valid_q  <= 1'b0;
			code_word_q  <= '0;
			final_word_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fc_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q  <= 1'b1;
				code_word_q  <= emit_word;
				final_word_q <= emit_final;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						eom_q <= end_of_message;
						if (mode == MODE_HEADER) begin
							frame_q  <= pager_address[2:0];
							acc_q    <= '0;
							held_q   <= '0;
							in_msg_q <= 1'b1;
							pre_q    <= PRE_W'(PREAMBLE_WORDS);
							state_q  <= S_PRE;
						end else if (in_msg_q) begin
							if (full) begin
								acc_q   <= rest_acc;
								held_q  <= {2'b00, ex};
								kind_q  <= CW_MSG;
								state_q <= S_CW;
							end else begin
								acc_q   <= joined[BITS_PER_WORD-1:0];
								held_q  <= sum;
								state_q <= end_of_message ? S_EOM : S_IDLE;
							end
						end
					end
				end
				S_PRE: begin
					if (emit) begin
						pre_q <= pre_q - PRE_W'(1);
						if (pre_q == PRE_W'(1)) begin
							state_q <= S_HSYNC;
						end
					end
				end
				S_HSYNC: begin
					if (emit) begin
						pad_q   <= {frame_q, 1'b0};
						kind_q  <= CW_ADDR;
						state_q <= (frame_q == 3'd0) ? S_CW : S_PAD;
					end
				end
				S_PAD: begin
					if (emit) begin
						pad_q <= pad_q - 4'd1;
						if (pad_q == 4'd1) begin
							state_q <= S_CW;
						end
					end
				end
				S_CW: begin
					if (emit) begin
						case (kind_q)
							CW_ADDR: begin
								batch_q <= {frame_q, 1'b1};
								state_q <= eom_q ? S_EOM : S_IDLE;
							end
							default: begin
								if (batch_q == BATCH_LAST) begin
									batch_q <= '0;
									state_q <= S_BSYNC;
								end else begin
									batch_q <= batch_q + 4'd1;
									state_q <= after_word;
								end
							end
						endcase
					end
				end
				S_BSYNC: begin
					if (emit) begin
						state_q <= after_word;
					end
				end
				S_EOM: begin
					if (held_q != 5'd0) begin
						kind_q  <= CW_FLUSH;
						acc_q   <= '0;
						held_q  <= '0;
						state_q <= S_CW;
					end else begin
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					if (emit) begin
						if (batch_q == BATCH_LAST) begin
							batch_q  <= '0;
							in_msg_q <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							batch_q <= batch_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign code_word  = code_word_q;
	assign final_word = final_word_q;

	`PTTE_ASSERT_ALWAYS(a_held_range, held_q < 5'd20, "bit count reached a full word")
	`PTTE_ASSERT_IMPL(a_bch_free, bch_start, !bch_busy, "BCH unit restarted while busy")
	`PTTE_ASSERT_NEXT(a_final_closes, emit && emit_final, !in_msg_q && state_q == S_IDLE,
		"transmission still open after final word")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the POCSAG text transmission encoder, with word-level prediction.
`default_nettype none

module tb_top
	import ptte_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PREAMBLE_LEN  = 18;
	localparam int BATCH_WORDS   = 16;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic        mode;
		logic [20:0] pager_address;
		logic [6:0]  character;
		logic        end_of_message;
	} item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 mode = 1'b0;
	logic [20:0]          pager_address = '0;
	logic [6:0]           character = '0;
	logic                 end_of_message = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CODE_BITS-1:0] code_word;
	logic                 final_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_data = '0;

	item_t       pending_items[$];
	logic [32:0] expected_words[$];
	item_t       next_item;
	item_t       seen_item;
	logic [32:0] want;

	logic [1:0]  fcode = 2'd3;
	logic [19:0] held_bits = '0;
	int          held_count = 0;
	int          batch_pos = 0;
	bit          msg_open = 1'b0;

	bit gen_open = 1'b0;
	bit in_taken = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int queued_items = 0;
	int accepted_items = 0;
	int header_items = 0;
	int checked_words = 0;
	int failures = 0;
	int cycle_count = 0;

	pocsag_text_transmission_encoder_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.pager_address  (pager_address),
		.character      (character),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_word      (code_word),
		.final_word     (final_word),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] bch_codeword(input logic [20:0] data);
		logic [30:0] r;
		r = {data, 10'b0};
		for (int i = 30; i >= 10; i--) begin
			if (r[i]) begin
				r = r ^ (31'(BCH_GEN) << (i - 10));
			end
		end
		return {data, r[9:0], ^{data, r[9:0]}};
	endfunction

	function automatic void emit_word(input logic [31:0] w);
		expected_words.push_back({1'b0, w});
	endfunction

	function automatic void emit_batch_word(input logic [31:0] w);
		emit_word(w);
		batch_pos++;
		if (batch_pos >= BATCH_WORDS) begin
			emit_word(SYNC_WORD);
			batch_pos = 0;
		end
	endfunction

	function automatic void close_transmission();
		logic [19:0] padded;
		logic [32:0] last;
		if (held_count > 0) begin
			padded = held_bits << (BITS_PER_WORD - held_count);
			emit_batch_word(bch_codeword(MESSAGE_FLAG | {1'b0, padded}));
		end
		held_bits = '0;
		held_count = 0;
		emit_word(IDLE_WORD);
		batch_pos++;
		while (batch_pos < BATCH_WORDS) begin
			emit_word(IDLE_WORD);
			batch_pos++;
		end
		batch_pos = 0;
		msg_open = 1'b0;
		last = expected_words.pop_back();
		last[32] = 1'b1;
		expected_words.push_back(last);
	endfunction

	function automatic void encode_item(input item_t it);
		if (it.mode == MODE_HEADER) begin
			for (int i = 0; i < PREAMBLE_LEN; i++) begin
				emit_word(PREAMBLE_PATTERN);
			end
			emit_word(SYNC_WORD);
			for (int i = 0; i < 2 * it.pager_address[2:0]; i++) begin
				emit_word(IDLE_WORD);
			end
			emit_word(bch_codeword({1'b0, it.pager_address[20:3], fcode}));
			batch_pos = 2 * it.pager_address[2:0] + 1;
			held_bits = '0;
			held_count = 0;
			msg_open = 1'b1;
		end else begin
			if (!msg_open) begin
				return;
			end
			for (int i = 0; i < BITS_PER_CHAR; i++) begin
				held_bits = {held_bits[18:0], it.character[i]};
				held_count++;
				if (held_count >= BITS_PER_WORD) begin
					emit_batch_word(bch_codeword(MESSAGE_FLAG | {1'b0, held_bits}));
					held_bits = '0;
					held_count = 0;
				end
			end
		end
		if (it.end_of_message) begin
			close_transmission();
		end
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		in_taken = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				fcode = cfg_data;
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				accepted_items++;
				seen_item = {mode, pager_address, character, end_of_message};
				if (seen_item.mode == MODE_HEADER) begin
					header_items++;
				end
				encode_item(seen_item);
			end
			if (out_valid && out_ready) begin
				checked_words++;
				if (expected_words.size() == 0) begin
					failures++;
					$display("%0t: unexpected word: expected none, got %h final %b",
						$time, code_word, final_word);
				end else begin
					want = expected_words.pop_front();
					if (code_word !== want[31:0] || final_word !== want[32]) begin
						failures++;
						$display("%0t: word mismatch: expected %h final %b, got %h final %b",
							$time, want[31:0], want[32], code_word, final_word);
					end
				end
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					mode <= next_item.mode;
					pager_address <= next_item.pager_address;
					character <= next_item.character;
					end_of_message <= next_item.end_of_message;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_item(input logic m, input logic [20:0] a, input logic [6:0] c,
		input logic e);
		pending_items.push_back({m, a, c, e});
		queued_items++;
	endtask

	task automatic gen_phase(input int target);
		int made;
		int len;
		logic [20:0] addr;
		made = 0;
		while (made < target) begin
			addr = 21'($urandom);
			if ($urandom_range(99) < 8) begin
				if (!gen_open) begin
					push_item(MODE_CHAR, addr, 7'($urandom), 1'($urandom));
				end else begin
					push_item(MODE_HEADER, addr, 7'($urandom), 1'b0);
					made++;
				end
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
				push_item(MODE_HEADER, addr, 7'($urandom), len == 0);
				gen_open = (len != 0);
				made++;
				for (int i = 1; i <= len; i++) begin
					push_item(MODE_CHAR, 21'($urandom), 7'($urandom), i == len);
					made++;
				end
				gen_open = 1'b0;
			end
		end
	endtask

	task automatic write_function_code(input logic [1:0] code);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (accepted_items != queued_items || expected_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [1:0] code, input int idle_pct, input int stall,
		input int count);
		write_function_code(code);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		gen_phase(count);
		wait_idle();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(MODE_CHAR, 21'h1FFFFF, 7'h7F, 1'b1);
		push_item(MODE_HEADER, 21'h000000, 7'h00, 1'b1);
		push_item(MODE_HEADER, 21'h1FFFFF, 7'h55, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h00, 1'b0);
		push_item(MODE_CHAR, 21'h1FFFFF, 7'h7F, 1'b0);
		push_item(MODE_CHAR, 21'h0AAAAA, 7'h41, 1'b0);
		push_item(MODE_CHAR, 21'h155555, 7'h2A, 1'b1);
		push_item(MODE_HEADER, 21'h000007, 7'h7F, 1'b1);
		push_item(MODE_HEADER, 21'h000006, 7'h00, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h7F, 1'b0);
		push_item(MODE_CHAR, 21'h1FFFFF, 7'h01, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h40, 1'b1);
		push_item(MODE_HEADER, 21'h000005, 7'h00, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h48, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h69, 1'b0);
		push_item(MODE_HEADER, 21'h0A5A5A, 7'h00, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h4F, 1'b0);
		push_item(MODE_CHAR, 21'h000000, 7'h4B, 1'b1);
		push_item(MODE_CHAR, 21'h0F0F0F, 7'h33, 1'b0);
		push_item(MODE_HEADER, 21'h1FFFF8, 7'h00, 1'b1);
		wait_idle();

		run_phase(2'd0, 0, 0, 58);
		run_phase(2'd3, 62, 0, 58);
		run_phase(2'd1, 0, 62, 58);
		run_phase(2'd2, 31, 31, 58);

		if (expected_words.size() != 0) begin
			failures += expected_words.size();
			$display("%0t: %0d expected words never arrived", $time, expected_words.size());
		end
		$display("Sent %0d items (%0d headers), checked %0d code words.",
			accepted_items, header_items, checked_words);
		$display("Function codes 3, 0, 3, 1, 2 over free, sender-idle, stalled and mixed flow.");
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
